### rtl/assert_macros.svh
// assertion macros for the checker file of the cursor linked list unit
// each macro expects clk and rst_n in scope; no other dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while in reset
`define CLL_ASSERT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("cursor linked list check failed");

// next-cycle implication, disabled while in reset
`define CLL_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("cursor linked list check failed");

`endif

### rtl/cll_pkg.sv
// cursor linked list package: port widths, operation codes and the microcode rom
// no dependencies; used by cursor_linked_list_unit
package cll_pkg;

    // stream payload widths
    localparam int KIND_W     = 2;
    localparam int POS_W      = 6;
    localparam int VAL_IN_W   = 32;
    localparam int ELEM_W     = 32;
    localparam int LEN_W      = 6;
    localparam int IN_DATA_W  = 40;
    localparam int IN_USER_W  = 2;
    localparam int OUT_DATA_W = 40;
    localparam int OUT_USER_W = 2;
    localparam int OUT_PAD_W  = OUT_DATA_W - ELEM_W - LEN_W;

    // operation kinds
    localparam logic [KIND_W-1:0] KIND_INS = 2'd0;
    localparam logic [KIND_W-1:0] KIND_ERS = 2'd1;
    localparam logic [KIND_W-1:0] KIND_TRV = 2'd2;

    // step addresses
    localparam int UA_W = 5;
    localparam logic [UA_W-1:0] U_IDLE  = 5'd0;
    localparam logic [UA_W-1:0] U_INS0  = 5'd1;
    localparam logic [UA_W-1:0] U_INS1  = 5'd2;
    localparam logic [UA_W-1:0] U_INS2  = 5'd3;
    localparam logic [UA_W-1:0] U_WLKI  = 5'd4;
    localparam logic [UA_W-1:0] U_INSL  = 5'd5;
    localparam logic [UA_W-1:0] U_INSE  = 5'd6;
    localparam logic [UA_W-1:0] U_ERS0  = 5'd7;
    localparam logic [UA_W-1:0] U_WLKE  = 5'd8;
    localparam logic [UA_W-1:0] U_ERS1  = 5'd9;
    localparam logic [UA_W-1:0] U_ERS2  = 5'd10;
    localparam logic [UA_W-1:0] U_ERS3  = 5'd11;
    localparam logic [UA_W-1:0] U_ERS4  = 5'd12;
    localparam logic [UA_W-1:0] U_TRV0  = 5'd13;
    localparam logic [UA_W-1:0] U_TRV1  = 5'd14;
    localparam logic [UA_W-1:0] U_TRV2  = 5'd15;
    localparam logic [UA_W-1:0] U_EMPTY = 5'd16;
    localparam logic [UA_W-1:0] U_ERR   = 5'd17;

    // link read address select
    localparam logic [1:0] RD_NONE = 2'd0;
    localparam logic [1:0] RD_FREE = 2'd1;
    localparam logic [1:0] RD_DATA = 2'd2;
    localparam logic [1:0] RD_LINK = 2'd3;

    // link write address and data select
    localparam logic [1:0] WA_FREE = 2'd0;
    localparam logic [1:0] WA_SLOT = 2'd1;
    localparam logic [1:0] WA_CUR  = 2'd2;
    localparam logic       WD_LINK = 1'b0;
    localparam logic       WD_SLOT = 1'b1;

    // cursor, hop counter and element count ops
    localparam logic [1:0] K_HOLD = 2'd0;
    localparam logic [1:0] K_DATA = 2'd1;
    localparam logic [1:0] K_LINK = 2'd2;
    localparam logic [1:0] N_HOLD = 2'd0;
    localparam logic [1:0] N_ONE  = 2'd1;
    localparam logic [1:0] N_INC  = 2'd2;
    localparam logic [1:0] C_HOLD = 2'd0;
    localparam logic [1:0] C_INC  = 2'd1;
    localparam logic [1:0] C_DEC  = 2'd2;

    // result emission
    localparam logic [1:0] EM_NONE = 2'd0;
    localparam logic [1:0] EM_OK   = 2'd1;
    localparam logic [1:0] EM_ERR  = 2'd2;
    localparam logic [1:0] EM_ELEM = 2'd3;

    // jump conditions
    localparam logic [2:0] CD_NEVER     = 3'd0;
    localparam logic [2:0] CD_LINK_ZERO = 3'd1;
    localparam logic [2:0] CD_N_EQ_POS  = 3'd2;
    localparam logic [2:0] CD_CNT_ZERO  = 3'd3;
    localparam logic [2:0] CD_N_EQ_CNT  = 3'd4;

    typedef struct packed {
        logic [1:0]      rd_sel;
        logic            val_rd;
        logic            lw_en;
        logic [1:0]      wa_sel;
        logic            wd_sel;
        logic            vw_en;
        logic [1:0]      k_op;
        logic            slot_ld;
        logic [1:0]      n_op;
        logic [1:0]      cnt_op;
        logic [1:0]      emit;
        logic [2:0]      cond;
        logic            guard;   // suppress actions when the jump is taken
        logic [UA_W-1:0] tgt;
        logic [UA_W-1:0] nxt;
    } uword_t;

    function automatic uword_t ucode_rom(input logic [UA_W-1:0] addr);
        uword_t w;
        w     = '0;
        w.tgt = U_IDLE;
        w.nxt = U_IDLE;
        unique case (addr)
            U_INS0:
            begin
                w.rd_sel = RD_FREE;
                w.nxt    = U_INS1;
            end
            U_INS1:
            begin
                w.slot_ld = 1'b1;
                w.rd_sel  = RD_LINK;
                w.cond    = CD_LINK_ZERO;
                w.tgt     = U_ERR;
                w.nxt     = U_INS2;
            end
            U_INS2:
            begin
                w.lw_en  = 1'b1;
                w.wa_sel = WA_FREE;
                w.wd_sel = WD_LINK;
                w.vw_en  = 1'b1;
                w.rd_sel = RD_DATA;
                w.k_op   = K_DATA;
                w.n_op   = N_ONE;
                w.nxt    = U_WLKI;
            end
            U_WLKI:
            begin
                w.cond   = CD_N_EQ_POS;
                w.guard  = 1'b1;
                w.tgt    = U_INSL;
                w.k_op   = K_LINK;
                w.rd_sel = RD_LINK;
                w.n_op   = N_INC;
                w.nxt    = U_WLKI;
            end
            U_INSL:
            begin
                w.lw_en  = 1'b1;
                w.wa_sel = WA_SLOT;
                w.wd_sel = WD_LINK;
                w.nxt    = U_INSE;
            end
            U_INSE:
            begin
                w.lw_en  = 1'b1;
                w.wa_sel = WA_CUR;
                w.wd_sel = WD_SLOT;
                w.cnt_op = C_INC;
                w.emit   = EM_OK;
                w.nxt    = U_IDLE;
            end
            U_ERS0:
            begin
                w.rd_sel = RD_DATA;
                w.k_op   = K_DATA;
                w.n_op   = N_ONE;
                w.nxt    = U_WLKE;
            end
            U_WLKE:
            begin
                w.cond   = CD_N_EQ_POS;
                w.guard  = 1'b1;
                w.tgt    = U_ERS1;
                w.k_op   = K_LINK;
                w.rd_sel = RD_LINK;
                w.n_op   = N_INC;
                w.nxt    = U_WLKE;
            end
            U_ERS1:
            begin
                w.slot_ld = 1'b1;
                w.rd_sel  = RD_LINK;
                w.nxt     = U_ERS2;
            end
            U_ERS2:
            begin
                w.lw_en  = 1'b1;
                w.wa_sel = WA_CUR;
                w.wd_sel = WD_LINK;
                w.rd_sel = RD_FREE;
                w.nxt    = U_ERS3;
            end
            U_ERS3:
            begin
                w.lw_en  = 1'b1;
                w.wa_sel = WA_SLOT;
                w.wd_sel = WD_LINK;
                w.nxt    = U_ERS4;
            end
            U_ERS4:
            begin
                w.lw_en  = 1'b1;
                w.wa_sel = WA_FREE;
                w.wd_sel = WD_SLOT;
                w.cnt_op = C_DEC;
                w.emit   = EM_OK;
                w.nxt    = U_IDLE;
            end
            U_TRV0:
            begin
                w.cond   = CD_CNT_ZERO;
                w.tgt    = U_EMPTY;
                w.rd_sel = RD_DATA;
                w.n_op   = N_ONE;
                w.nxt    = U_TRV1;
            end
            U_TRV1:
            begin
                w.rd_sel = RD_LINK;
                w.val_rd = 1'b1;
                w.nxt    = U_TRV2;
            end
            U_TRV2:
            begin
                w.emit   = EM_ELEM;
                w.cond   = CD_N_EQ_CNT;
                w.tgt    = U_IDLE;
                w.rd_sel = RD_LINK;
                w.val_rd = 1'b1;
                w.n_op   = N_INC;
                w.nxt    = U_TRV2;
            end
            U_EMPTY:
            begin
                w.emit = EM_OK;
                w.nxt  = U_IDLE;
            end
            U_ERR:
            begin
                w.emit = EM_ERR;
                w.nxt  = U_IDLE;
            end
            default:
            begin
                w.nxt = U_IDLE;
            end
        endcase
        return w;
    endfunction

endpackage

### rtl/cursor_linked_list_unit.sv
// cursor linked list unit: microcoded sequencer over a link memory and a value memory
// depends on cll_pkg (widths, codes, microcode rom)
// insert and erase walk the chain to the position, traverse to the length; a bad
// position, unused kind or insert into a full store ends in the error step; any output
// stall adds to each; throughput: one item at a time; the link walk makes one hop per
// cycle on the single read port of the link memory
// reset: step counter idle, element count zero, link valid flags cleared at once so
// the free chain reads as its reset pattern; no clearing pass, value memory not reset
module cursor_linked_list_unit #(
    parameter int SLOTS       = 64,
    parameter int VALUE_WIDTH = 32
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    input  logic [cll_pkg::IN_DATA_W-1:0]    s_axis_tdata,   // position, value, zero pad
    input  logic [cll_pkg::IN_USER_W-1:0]    s_axis_tuser,   // kind
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    output logic [cll_pkg::OUT_DATA_W-1:0]   m_axis_tdata,   // element, length, zero pad
    output logic [cll_pkg::OUT_USER_W-1:0]   m_axis_tuser,   // status, has_value
    output logic                             m_axis_tlast
);
    import cll_pkg::*;

    // slot index and element count widths
    localparam int SW = $clog2(SLOTS);
    localparam int CW = $clog2(SLOTS - 1);
    localparam logic [SW-1:0] FREE_SLOT = '0;             // heads the free chain
    localparam logic [SW-1:0] DATA_SLOT = SW'(SLOTS - 1); // heads the data chain

    // reset pattern of the link store: free chain 0 -> 1 -> ... -> SLOTS-2 -> 0
    function automatic logic [SW-1:0] link_init(input logic [SW-1:0] idx);
        logic [SW-1:0] res;
        res = '0;
        if (idx < SW'(SLOTS - 2))
        begin
            res = idx + SW'(1);
        end
        return res;
    endfunction

    // sequencer and datapath registers
    logic [UA_W-1:0]        upc_reg, upc_next;
    logic [CW-1:0]          cnt_reg, cnt_next;
    logic [SW-1:0]          pos_reg;
    logic [VALUE_WIDTH-1:0] val_reg;
    logic [SW-1:0]          cur_reg;    // cursor slot of the walk
    logic [SW-1:0]          slot_reg;   // allocated or unlinked slot
    logic [SW-1:0]          n_reg;      // hop or element counter

    // link memory with one write and one registered read port
    logic [SW-1:0]          link_mem_reg [SLOTS];
    logic [SLOTS-1:0]       link_vld_reg;
    logic [SW-1:0]          link_q_reg;
    logic [SW-1:0]          link_addr_reg;
    logic                   link_hit_reg;

    // value memory, contents undefined until written
    logic [VALUE_WIDTH-1:0] value_mem_reg [SLOTS];
    logic [VALUE_WIDTH-1:0] value_q_reg;

    // output register
    logic                   m_valid_reg;
    logic                   m_status_reg;
    logic                   m_has_reg;
    logic [ELEM_W-1:0]      m_elem_reg;
    logic [LEN_W-1:0]       m_len_reg;
    logic                   m_last_reg;

    uword_t                 uw;
    logic [SW-1:0]          link_rd;
    logic                   cond_true;
    logic                   stall;
    logic                   act;
    logic                   accept;
    logic [KIND_W-1:0]      in_kind;
    logic [POS_W-1:0]       in_pos;
    logic [VAL_IN_W-1:0]    in_val;
    logic                   ins_pos_ok;
    logic                   ers_pos_ok;
    logic [UA_W-1:0]        entry;
    logic                   rd_en;
    logic [SW-1:0]          rd_addr;
    logic                   lw_en;
    logic [SW-1:0]          lw_addr;
    logic [SW-1:0]          lw_data;

    // current control word
    assign uw = ucode_rom(upc_reg);

    // link read data, entries never written show their reset pattern
    assign link_rd = link_hit_reg ? link_q_reg : link_init(link_addr_reg);

    // input unpacking
    assign in_kind = s_axis_tuser;
    assign in_pos  = s_axis_tdata[POS_W-1:0];
    assign in_val  = s_axis_tdata[POS_W +: VAL_IN_W];

    // only the idle step takes a new item
    assign s_axis_tready = (upc_reg == U_IDLE);
    assign accept        = s_axis_tvalid && s_axis_tready;

    // position checks: insert 1..length+1, erase 1..length
    assign ins_pos_ok = (in_pos != '0) &&
                        ({1'b0, in_pos} <= (7'(cnt_reg) + 7'd1));
    assign ers_pos_ok = (in_pos != '0) && (in_pos <= 6'(cnt_reg));

    always_comb
    begin
        unique case (in_kind)
            KIND_INS: entry = ins_pos_ok ? U_INS0 : U_ERR;
            KIND_ERS: entry = ers_pos_ok ? U_ERS0 : U_ERR;
            KIND_TRV: entry = U_TRV0;
            default:  entry = U_ERR;
        endcase
    end

    // jump condition decode
    always_comb
    begin
        unique case (uw.cond)
            CD_LINK_ZERO: cond_true = (link_rd == '0);
            CD_N_EQ_POS:  cond_true = (n_reg == pos_reg);
            CD_CNT_ZERO:  cond_true = (cnt_reg == '0);
            CD_N_EQ_CNT:  cond_true = (n_reg == SW'(cnt_reg));
            default:      cond_true = 1'b0;
        endcase
    end

    // a step that emits waits for the output register; a guarded step does nothing
    // but jump when its condition holds
    assign stall = (uw.emit != EM_NONE) && m_valid_reg && !m_axis_tready;
    assign act   = !stall && !(uw.guard && cond_true);

    always_comb
    begin
        upc_next = upc_reg;
        if (upc_reg == U_IDLE)
        begin
            if (accept)
            begin
                upc_next = entry;
            end
        end
        else if (!stall)
        begin
            upc_next = cond_true ? uw.tgt : uw.nxt;
        end
    end

    // link read address
    always_comb
    begin
        unique case (uw.rd_sel)
            RD_FREE: rd_addr = FREE_SLOT;
            RD_DATA: rd_addr = DATA_SLOT;
            RD_LINK: rd_addr = link_rd;
            default: rd_addr = FREE_SLOT;
        endcase
    end
    assign rd_en = act && (uw.rd_sel != RD_NONE);

    // link write address and data
    always_comb
    begin
        unique case (uw.wa_sel)
            WA_SLOT: lw_addr = slot_reg;
            WA_CUR:  lw_addr = cur_reg;
            default: lw_addr = FREE_SLOT;
        endcase
    end
    assign lw_data = (uw.wd_sel == WD_SLOT) ? slot_reg : link_rd;
    assign lw_en   = act && uw.lw_en;

    // element count update
    always_comb
    begin
        cnt_next = cnt_reg;
        if (act)
        begin
            case (uw.cnt_op)
                C_INC:   cnt_next = cnt_reg + CW'(1);
                C_DEC:   cnt_next = cnt_reg - CW'(1);
                default: cnt_next = cnt_reg;
            endcase
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            upc_reg <= U_IDLE;
            cnt_reg <= '0;
        end
        else
        begin
            upc_reg <= upc_next;
            cnt_reg <= cnt_next;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            pos_reg <= SW'(in_pos);
            val_reg <= VALUE_WIDTH'(in_val);
        end
        if (act)
        begin
            case (uw.k_op)
                K_DATA:  cur_reg <= DATA_SLOT;
                K_LINK:  cur_reg <= link_rd;
                default: cur_reg <= cur_reg;
            endcase
            case (uw.n_op)
                N_ONE:   n_reg <= SW'(1);
                N_INC:   n_reg <= n_reg + SW'(1);
                default: n_reg <= n_reg;
            endcase
            if (uw.slot_ld)
            begin
                slot_reg <= link_rd;
            end
        end
    end

    // link memory
    always_ff @(posedge clk)
    begin
        if (lw_en)
        begin
            link_mem_reg[lw_addr] <= lw_data;
        end
        if (rd_en)
        begin
            link_q_reg    <= link_mem_reg[rd_addr];
            link_addr_reg <= rd_addr;
            link_hit_reg  <= link_vld_reg[rd_addr];
        end
    end

    // one valid flag per link entry, cleared by reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            link_vld_reg <= '0;
        end
        else if (lw_en)
        begin
            link_vld_reg[lw_addr] <= 1'b1;
        end
    end

    // value memory
    always_ff @(posedge clk)
    begin
        if (act && uw.vw_en)
        begin
            value_mem_reg[slot_reg] <= val_reg;
        end
        if (act && uw.val_rd)
        begin
            value_q_reg <= value_mem_reg[link_rd];
        end
    end

    // output register, refilled while the previous item drains
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_valid_reg <= 1'b0;
        end
        else if (act && (uw.emit != EM_NONE))
        begin
            m_valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (act && (uw.emit != EM_NONE))
        begin
            m_status_reg <= (uw.emit == EM_ERR);
            m_has_reg    <= (uw.emit == EM_ELEM);
            m_elem_reg   <= (uw.emit == EM_ELEM) ? ELEM_W'(value_q_reg) : '0;
            m_len_reg    <= LEN_W'(cnt_next);
            // only the final traversed element, or the plain result of an empty list, closes a traverse
            m_last_reg   <= (uw.emit == EM_ELEM) ? (n_reg == SW'(cnt_reg)) : 1'b1;
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = {{OUT_PAD_W{1'b0}}, m_len_reg, m_elem_reg};
    assign m_axis_tuser  = {m_has_reg, m_status_reg};
    assign m_axis_tlast  = m_last_reg;

endmodule

### rtl/cll_checker.sv
// port-level checks for cursor_linked_list_unit, attached by bind
// depends on assert_macros.svh
module cll_checker #(
    parameter int SLOTS = 64
) (
    input logic        clk,
    input logic        rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [39:0] m_axis_tdata,
    input logic [1:0]  m_axis_tuser,
    input logic        m_axis_tlast
);
`include "assert_macros.svh"

    // a taken item leaves the sequencer busy in the next cycle
    `CLL_ASSERT_NEXT(a_busy_after_take, s_axis_tvalid && s_axis_tready, !s_axis_tready)

    // a stalled result holds
    `CLL_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser) && $stable(m_axis_tlast))

    // a result without an element is the only result of its item and carries a zero element
    `CLL_ASSERT(a_plain_last, m_axis_tvalid && !m_axis_tuser[1], m_axis_tlast && (m_axis_tdata[31:0] == 32'd0))

    // length never exceeds the usable slots
    `CLL_ASSERT(a_len_max, m_axis_tvalid, m_axis_tdata[37:32] <= 6'(SLOTS - 2))

endmodule

bind cursor_linked_list_unit cll_checker #(.SLOTS(SLOTS)) u_cll_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
);
